[hdl/sgid_pkg.sv]
`default_nettype none

package sgid_pkg;

  // Fixed field widths
  localparam int POS_W    = 48;
  localparam int BYTE_W   = 8;
  localparam int HIST_W   = 16;
  localparam int DIM_W    = 16;
  localparam int CH_W     = 3;
  localparam int INFO_W   = 18;
  localparam int PROD_W   = INFO_W + DIM_W;
  localparam int STATUS_W = 2;

  // Header constants
  localparam logic [HIST_W-1:0] MAGIC_WORD = 16'h01DA;
  localparam int DATA_OFFSET     = 512;
  localparam int MIN_FIRST_BLOCK = 128;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Header field offsets, counted from the second magic byte
  localparam int OFS_W = 4;
  localparam logic [OFS_W-1:0] OFS_STORAGE  = 4'd1;
  localparam logic [OFS_W-1:0] OFS_BPC      = 4'd2;
  localparam logic [OFS_W-1:0] OFS_DIM      = 4'd4;
  localparam logic [OFS_W-1:0] OFS_WIDTH    = 4'd6;
  localparam logic [OFS_W-1:0] OFS_HEIGHT   = 4'd8;
  localparam logic [OFS_W-1:0] OFS_CHANNELS = 4'd10;

  // Small queues between the stages
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_BUSY     = 2'd1,
    STATUS_FOUND    = 2'd2,
    STATUS_DISABLED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_CAND,
    SCAN_FOUND
  } scan_t;

  typedef enum logic [1:0] {
    SEQ_RUN,
    SEQ_MUL,
    SEQ_END,
    SEQ_PUSH
  } seq_t;

  // Classified input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              new_block;
    logic [POS_W-1:0]  block_pos;
    logic              disabled;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_out_t;

  // Result beat
  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  image_start;
    logic [POS_W-1:0]  image_end;
    logic [INFO_W-1:0] info;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } rq_t;

  // Add that sticks at the all-ones position
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/sgid_front.sv]
`default_nettype none

// Input side: flags short first blocks, queues beats for the scanner.
module sgid_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [sgid_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_new_block,
  input  logic [sgid_pkg::POS_W-1:0]       in_block_pos,
  input  logic [sgid_pkg::POS_W-1:0]       in_block_len,
  output sgid_pkg::fq_out_t                fq_o,
  input  logic                             fq_take
);

  sgid_pkg::item_t              q_r [sgid_pkg::QUEUE_DEPTH];
  logic [sgid_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sgid_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sgid_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  sgid_pkg::item_t              item;
  logic                         push_ok;
  logic                         pop_ok;

  always_comb begin
    item.data_byte = in_data_byte;
    item.new_block = in_new_block;
    item.block_pos = in_block_pos;
    item.disabled  = (in_block_pos == '0) &&
                     (in_block_len < sgid_pkg::POS_W'(sgid_pkg::MIN_FIRST_BLOCK));
  end

  assign in_full = (cnt_r == sgid_pkg::QCNT_W'(sgid_pkg::QUEUE_DEPTH));
  assign push_ok = in_push && !in_full;
  assign pop_ok  = fq_take && (cnt_r != '0);

  assign fq_o.valid = (cnt_r != '0);
  assign fq_o.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == sgid_pkg::QPTR_W'(sgid_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == sgid_pkg::QPTR_W'(sgid_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

[hdl/sgid_back.sv]
`default_nettype none

// Scanner: magic match, header field checks, then a short sequence that
// forms the image end from width, height and channels.
module sgid_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sgid_pkg::fq_out_t  fq_i,
  output logic               fq_take,
  output sgid_pkg::rq_t      rq_o,
  input  logic               rq_room
);

  sgid_pkg::scan_t                scan_r, scan_nxt;
  sgid_pkg::seq_t                 seq_r, seq_nxt;
  logic [sgid_pkg::HIST_W-1:0]    hist_r, hist_nxt;
  logic [sgid_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [sgid_pkg::POS_W-1:0]     magic_r, magic_nxt;
  logic [sgid_pkg::DIM_W-1:0]     width_r, width_nxt;
  logic [sgid_pkg::DIM_W-1:0]     height_r, height_nxt;
  logic [sgid_pkg::POS_W-1:0]     start_r, start_nxt;
  logic [sgid_pkg::POS_W-1:0]     end_r, end_nxt;
  logic [sgid_pkg::INFO_W-1:0]    info_r, info_nxt;
  logic [sgid_pkg::PROD_W-1:0]    prod_r, prod_nxt;

  sgid_pkg::item_t                it;
  logic [sgid_pkg::POS_W-1:0]     sp;
  logic [sgid_pkg::HIST_W-1:0]    hist_new;
  logic [sgid_pkg::POS_W-1:0]     hdr_ofs;
  logic                           chan_ok;
  logic                           dim_ok;
  logic                           hit;

  assign it       = fq_i.item;
  assign sp       = it.new_block ? it.block_pos : pos_r;
  assign hist_new = {hist_r[sgid_pkg::BYTE_W-1:0], it.data_byte};
  assign hdr_ofs  = sp - magic_r;
  assign chan_ok  = (hist_new == 16'd1) || (hist_new == 16'd3) || (hist_new == 16'd4);
  assign dim_ok   = (hist_new == 16'd1) || (hist_new == 16'd2) || (hist_new == 16'd3);
  assign fq_take  = fq_i.valid && (seq_r == sgid_pkg::SEQ_RUN) && rq_room;

  always_comb begin
    scan_nxt   = scan_r;
    seq_nxt    = seq_r;
    hist_nxt   = hist_r;
    pos_nxt    = pos_r;
    magic_nxt  = magic_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    info_nxt   = info_r;
    prod_nxt   = prod_r;
    hit        = 1'b0;

    rq_o.valid           = 1'b0;
    rq_o.res.status      = sgid_pkg::STATUS_NONE;
    rq_o.res.image_start = start_r;
    rq_o.res.image_end   = end_r;
    rq_o.res.info        = info_r;

    unique case (seq_r)
      sgid_pkg::SEQ_RUN: begin
        if (fq_take) begin
          if (it.disabled) begin
            rq_o.valid      = 1'b1;
            rq_o.res.status = sgid_pkg::STATUS_DISABLED;
          end else begin
            hist_nxt = hist_new;
            unique case (scan_r)
              sgid_pkg::SCAN_IDLE: begin
                if (hist_new == sgid_pkg::MAGIC_WORD) begin
                  scan_nxt   = sgid_pkg::SCAN_CAND;
                  magic_nxt  = sp;
                  width_nxt  = '0;
                  height_nxt = '0;
                end
              end
              sgid_pkg::SCAN_CAND: begin
                if (hdr_ofs > sgid_pkg::POS_W'(sgid_pkg::OFS_CHANNELS)) begin
                  // position reload jumped past the header
                  scan_nxt = sgid_pkg::SCAN_IDLE;
                end else begin
                  unique case (hdr_ofs[sgid_pkg::OFS_W-1:0])
                    sgid_pkg::OFS_STORAGE: begin
                      if (it.data_byte != 8'd0) scan_nxt = sgid_pkg::SCAN_IDLE;
                    end
                    sgid_pkg::OFS_BPC: begin
                      if (it.data_byte != 8'd1) scan_nxt = sgid_pkg::SCAN_IDLE;
                    end
                    sgid_pkg::OFS_DIM: begin
                      if (!dim_ok) scan_nxt = sgid_pkg::SCAN_IDLE;
                    end
                    sgid_pkg::OFS_WIDTH: begin
                      width_nxt = hist_new;
                      if (hist_new == '0) scan_nxt = sgid_pkg::SCAN_IDLE;
                    end
                    sgid_pkg::OFS_HEIGHT: begin
                      height_nxt = hist_new;
                      if (hist_new == '0) scan_nxt = sgid_pkg::SCAN_IDLE;
                    end
                    sgid_pkg::OFS_CHANNELS: begin
                      if ((width_r != '0) && (height_r != '0) && chan_ok) begin
                        hit       = 1'b1;
                        scan_nxt  = sgid_pkg::SCAN_FOUND;
                        info_nxt  = sgid_pkg::INFO_W'(height_r) *
                                    sgid_pkg::INFO_W'(hist_new[sgid_pkg::CH_W-1:0]);
                        start_nxt = sgid_pkg::sat_add(magic_r,
                                      sgid_pkg::POS_W'(sgid_pkg::DATA_OFFSET - 1));
                        seq_nxt   = sgid_pkg::SEQ_MUL;
                      end else begin
                        scan_nxt = sgid_pkg::SCAN_IDLE;
                      end
                    end
                    default: ;
                  endcase
                end
              end
              sgid_pkg::SCAN_FOUND: ;
              default: ;
            endcase
            pos_nxt = sp + sgid_pkg::POS_W'(sp != sgid_pkg::POS_MAX);
            if (!hit) begin
              rq_o.valid      = 1'b1;
              rq_o.res.status = (scan_nxt != sgid_pkg::SCAN_IDLE) ?
                                sgid_pkg::STATUS_BUSY : sgid_pkg::STATUS_NONE;
            end
          end
        end
      end
      sgid_pkg::SEQ_MUL: begin
        prod_nxt = sgid_pkg::PROD_W'(info_r) * sgid_pkg::PROD_W'(width_r);
        seq_nxt  = sgid_pkg::SEQ_END;
      end
      sgid_pkg::SEQ_END: begin
        end_nxt = sgid_pkg::sat_add(start_r, sgid_pkg::POS_W'(prod_r));
        seq_nxt = sgid_pkg::SEQ_PUSH;
      end
      sgid_pkg::SEQ_PUSH: begin
        if (rq_room) begin
          rq_o.valid      = 1'b1;
          rq_o.res.status = sgid_pkg::STATUS_FOUND;
          seq_nxt         = sgid_pkg::SEQ_RUN;
        end
      end
      default: seq_nxt = sgid_pkg::SEQ_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= sgid_pkg::SCAN_IDLE;
      seq_r    <= sgid_pkg::SEQ_RUN;
      hist_r   <= '0;
      pos_r    <= '0;
      magic_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      start_r  <= '0;
      end_r    <= '0;
      info_r   <= '0;
    end else begin
      scan_r   <= scan_nxt;
      seq_r    <= seq_nxt;
      hist_r   <= hist_nxt;
      pos_r    <= pos_nxt;
      magic_r  <= magic_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      info_r   <= info_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

[hdl/sgid_outq.sv]
`default_nettype none

// Result queue: holds finished beats until the consumer pops them.
module sgid_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sgid_pkg::rq_t                 rq_i,
  output logic                          rq_room,
  output logic                          out_empty,
  input  logic                          out_pop,
  output sgid_pkg::res_t                res_o
);

  sgid_pkg::res_t               q_r [sgid_pkg::QUEUE_DEPTH];
  logic [sgid_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sgid_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sgid_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         push_ok;
  logic                         pop_ok;

  assign rq_room   = (cnt_r != sgid_pkg::QCNT_W'(sgid_pkg::QUEUE_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign push_ok   = rq_i.valid && rq_room;
  assign pop_ok    = out_pop && !out_empty;
  assign res_o     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == sgid_pkg::QPTR_W'(sgid_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == sgid_pkg::QPTR_W'(sgid_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= rq_i.res;
    end
  end

endmodule

`default_nettype wire

[hdl/sgi_image_header_detector_unit.sv]
`default_nettype none

// Channel   Ports                                          Beat
// ------    ---------------------------------------------  -------------------------
// input     in_push/in_full, in_data_byte, in_new_block,   one stream byte with its
//           in_block_pos, in_block_len                     block position and length
// result    out_pop/out_empty, out_status, out_image_start, one status per input byte
//           out_image_end, out_rows_times_channels
//
// One result per byte, one byte per cycle through the scanner while it runs and the
// result queue has room. The byte that completes a valid header holds the scanner for
// the channels check, width multiply, saturating end add and push; the two-deep
// queues on each side soak that up. Reset is synchronous and clears both queues and
// all scan state. in_full rises only when the input queue holds two beats; out_empty
// drops as soon as a result sits in the output queue, whether or not it is popped.
module sgi_image_header_detector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [sgid_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_new_block,
  input  logic [sgid_pkg::POS_W-1:0]       in_block_pos,
  input  logic [sgid_pkg::POS_W-1:0]       in_block_len,
  // result channel
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [sgid_pkg::STATUS_W-1:0]    out_status,
  output logic [sgid_pkg::POS_W-1:0]       out_image_start,
  output logic [sgid_pkg::POS_W-1:0]       out_image_end,
  output logic [sgid_pkg::INFO_W-1:0]      out_rows_times_channels
);

  sgid_pkg::fq_out_t  fq;
  logic               fq_take;
  sgid_pkg::rq_t      rq;
  logic               rq_room;
  sgid_pkg::res_t     res;

  // front: short-first-block check and input queue
  sgid_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_new_block (in_new_block),
    .in_block_pos (in_block_pos),
    .in_block_len (in_block_len),
    .fq_o         (fq),
    .fq_take      (fq_take)
  );

  // back: magic match, header checks, image bounds
  sgid_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .fq_i    (fq),
    .fq_take (fq_take),
    .rq_o    (rq),
    .rq_room (rq_room)
  );

  // result queue toward the consumer
  sgid_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rq_i      (rq),
    .rq_room   (rq_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res_o     (res)
  );

  assign out_status              = res.status;
  assign out_image_start         = res.image_start;
  assign out_image_end           = res.image_end;
  assign out_rows_times_channels = res.info;

endmodule

`default_nettype wire

[hdl/sgid_checker.sv]
`default_nettype none

module sgid_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_full,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  logic [sgid_pkg::STATUS_W-1:0]    out_status,
  input  logic [sgid_pkg::POS_W-1:0]       out_image_start,
  input  logic [sgid_pkg::POS_W-1:0]       out_image_end,
  input  logic [sgid_pkg::INFO_W-1:0]      out_rows_times_channels
);

  logic seen_r, seen_nxt;
  logic pop_beat;
  logic found_beat;

  assign pop_beat   = out_pop && !out_empty;
  assign found_beat = (out_status == sgid_pkg::STATUS_FOUND);
  assign seen_nxt   = seen_r || (pop_beat && found_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result holds still until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_status) &&
      $stable(out_image_start) && $stable(out_image_end))
    else $error("stalled result changed");

  // only one found beat, and never a plain none afterwards
  a_found_once: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r && !out_empty |->
      out_status != sgid_pkg::STATUS_FOUND && out_status != sgid_pkg::STATUS_NONE)
    else $error("status after image found is wrong");

  // found beat carries ordered bounds and a nonzero rows times channels
  a_found_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && found_beat |->
      out_image_end >= out_image_start && out_rows_times_channels != '0)
    else $error("found beat bounds inconsistent");

  // before any image, result fields are zero
  a_zero_before: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r && !out_empty && !found_beat |->
      out_image_start == '0 && out_image_end == '0 && out_rows_times_channels == '0)
    else $error("nonzero bounds before image found");

endmodule

bind sgi_image_header_detector_unit sgid_checker u_sgid_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_full                 (in_full),
  .out_empty               (out_empty),
  .out_pop                 (out_pop),
  .out_status              (out_status),
  .out_image_start         (out_image_start),
  .out_image_end           (out_image_end),
  .out_rows_times_channels (out_rows_times_channels)
);

`default_nettype wire
